// File: hw/rtl/fixed_point_q24_8_alu_assert.svh
// Assertion macros for the Q24.8 ALU.
// Included by the top level; no other dependencies.
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`ifndef ASSERT_OFF
`define FXQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fxq assertion failed");
`define FXQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fxq assertion failed");
`else
`define FXQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FXQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/fxq_pkg.sv
// Shared types and codes for the Q24.8 ALU.
// No dependencies.
`default_nettype none
package fxq_pkg;
    localparam int OPW    = 32;   // operand and result width
    localparam int WIDE_W = 66;   // headroom for unclamped results

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_LT   = 4'd4;
    localparam logic [3:0] OP_GT   = 4'd5;
    localparam logic [3:0] OP_LE   = 4'd6;
    localparam logic [3:0] OP_GE   = 4'd7;
    localparam logic [3:0] OP_EQ   = 4'd8;
    localparam logic [3:0] OP_NE   = 4'd9;
    localparam logic [3:0] OP_MIN  = 4'd10;
    localparam logic [3:0] OP_MAX  = 4'd11;
    localparam logic [3:0] OP_INC  = 4'd12;
    localparam logic [3:0] OP_DEC  = 4'd13;
    localparam logic [3:0] OP_FINT = 4'd14;
    localparam logic [3:0] OP_TINT = 4'd15;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic       clamp;     // result saturates to the data range
        logic       neg;       // mul/div result sign
        logic       div_zero;
        logic       cmp;
    } ctl_t;
endpackage
`default_nettype wire

// File: hw/rtl/fxq_front.sv
// Decode stage: operand magnitudes, product, simple results, divider setup.
// Depends on fxq_pkg.
`default_nettype none
module fxq_front #(
    parameter int FRAC_BITS = 8,
    parameter int NUM_W     = 40
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  [3:0]                        operation,
    input  wire  signed [fxq_pkg::OPW-1:0]    operand_a,
    input  wire  signed [fxq_pkg::OPW-1:0]    operand_b,
    output logic                              out_valid,
    input  wire                               out_ready,
    output fxq_pkg::ctl_t                     out_ctl,
    output logic signed [fxq_pkg::WIDE_W-1:0] out_val,
    output logic [NUM_W-1:0]                  out_num,
    output logic [fxq_pkg::OPW-1:0]           out_den
);
    import fxq_pkg::*;

    logic                     valid_reg;
    ctl_t                     ctl_reg, ctl_next;
    logic signed [WIDE_W-1:0] val_reg, val_next;
    logic [NUM_W-1:0]         num_reg;
    logic [OPW-1:0]           den_reg;

    logic signed [WIDE_W-1:0] a_w, b_w;
    logic [OPW-1:0]           a_mag, b_mag;
    logic [2*OPW-1:0]         prod;
    logic                     lt, gt, eq;

    assign a_w   = {{(WIDE_W-OPW){operand_a[OPW-1]}}, operand_a};
    assign b_w   = {{(WIDE_W-OPW){operand_b[OPW-1]}}, operand_b};
    assign a_mag = operand_a[OPW-1] ? OPW'(-operand_a) : operand_a;
    assign b_mag = operand_b[OPW-1] ? OPW'(-operand_b) : operand_b;
    assign prod  = a_mag * b_mag;
    assign lt    = operand_a < operand_b;
    assign gt    = operand_a > operand_b;
    assign eq    = operand_a == operand_b;

    always_comb
    begin
        ctl_next          = '0;
        ctl_next.op       = operation;
        ctl_next.neg      = operand_a[OPW-1] ^ operand_b[OPW-1];
        ctl_next.div_zero = (operation == OP_DIV) && (operand_b == '0);
        val_next          = '0;
        unique case (operation)
            OP_ADD:  begin val_next = a_w + b_w; ctl_next.clamp = 1'b1; end
            OP_SUB:  begin val_next = a_w - b_w; ctl_next.clamp = 1'b1; end
            OP_MUL:  begin val_next = WIDE_W'(prod); ctl_next.clamp = 1'b1; end
            OP_DIV:  ctl_next.clamp = 1'b1;
            OP_LT:   ctl_next.cmp = lt;
            OP_GT:   ctl_next.cmp = gt;
            OP_LE:   ctl_next.cmp = lt | eq;
            OP_GE:   ctl_next.cmp = gt | eq;
            OP_EQ:   ctl_next.cmp = eq;
            OP_NE:   ctl_next.cmp = !eq;
            OP_MIN:  val_next = lt ? a_w : b_w;
            OP_MAX:  val_next = gt ? a_w : b_w;
            OP_INC:  begin val_next = a_w + WIDE_W'(1); ctl_next.clamp = 1'b1; end
            OP_DEC:  begin val_next = a_w - WIDE_W'(1); ctl_next.clamp = 1'b1; end
            OP_FINT: begin val_next = a_w <<< FRAC_BITS; ctl_next.clamp = 1'b1; end
            OP_TINT: val_next = a_w >>> FRAC_BITS;
            default: val_next = '0;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ctl_reg <= ctl_next;
            val_reg <= val_next;
            num_reg <= {a_mag, FRAC_BITS'(0)};
            den_reg <= b_mag;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_val   = val_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
endmodule
`default_nettype wire

// File: hw/rtl/fxq_div_cell.sv
// One restoring-division step; request+payload move each cycle unless stalled.
// Depends on fxq_pkg.
`default_nettype none
module fxq_div_cell #(
    parameter int NUM_W = 40
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  fxq_pkg::ctl_t                     in_ctl,
    input  wire  signed [fxq_pkg::WIDE_W-1:0] in_val,
    input  wire  [NUM_W-1:0]                  in_num,
    input  wire  [fxq_pkg::OPW-1:0]           in_rem,
    input  wire  [fxq_pkg::OPW-1:0]           in_den,
    output logic                              out_valid,
    input  wire                               out_ready,
    output fxq_pkg::ctl_t                     out_ctl,
    output logic signed [fxq_pkg::WIDE_W-1:0] out_val,
    output logic [NUM_W-1:0]                  out_num,
    output logic [fxq_pkg::OPW-1:0]           out_rem,
    output logic [fxq_pkg::OPW-1:0]           out_den
);
    import fxq_pkg::*;

    logic                     valid_reg;
    ctl_t                     ctl_reg;
    logic signed [WIDE_W-1:0] val_reg;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [OPW-1:0]           rem_reg, rem_next;
    logic [OPW-1:0]           den_reg;
    logic [OPW:0]             trial, diff;
    logic                     qbit;

    // shift next numerator bit into the partial remainder
    assign trial    = {in_rem, in_num[NUM_W-1]};
    assign diff     = trial - {1'b0, in_den};
    assign qbit     = trial >= {1'b0, in_den};
    assign rem_next = qbit ? diff[OPW-1:0] : trial[OPW-1:0];
    assign num_next = {in_num[NUM_W-2:0], qbit};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ctl_reg <= in_ctl;
            val_reg <= in_val;
            num_reg <= num_next;
            rem_reg <= rem_next;
            den_reg <= in_den;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_val   = val_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
endmodule
`default_nettype wire

// File: hw/rtl/fxq_finish.sv
// Rounding and sign stage, then saturation into the output register.
// Depends on fxq_pkg.
`default_nettype none
module fxq_finish #(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 32,
    parameter int NUM_W      = 40
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  fxq_pkg::ctl_t                     in_ctl,
    input  wire  signed [fxq_pkg::WIDE_W-1:0] in_val,
    input  wire  [NUM_W-1:0]                  in_num,
    input  wire  [fxq_pkg::OPW-1:0]           in_rem,
    input  wire  [fxq_pkg::OPW-1:0]           in_den,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [fxq_pkg::OPW-1:0]           result_value,
    output logic                              compare_true,
    output logic [1:0]                        status
);
    import fxq_pkg::*;

    localparam logic signed [WIDE_W-1:0] HI = (WIDE_W'(1) <<< (DATA_WIDTH-1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] LO = -HI - WIDE_W'(1);

    logic                     valid_a_reg, valid_b_reg;
    logic                     ready_a, ready_b;
    ctl_t                     ctl_a_reg;
    logic signed [WIDE_W-1:0] res_a_reg, res_a_next;
    logic [OPW-1:0]           data_reg, data_next;
    logic                     cmp_reg;
    logic [1:0]               status_reg, status_next;

    logic [2*OPW-1:0]         mul_m;
    logic [NUM_W:0]           div_m;
    logic                     round_up;
    logic signed [WIDE_W-1:0] mag_w;

    // mul: add half an LSB then drop fraction; div: round on remainder
    assign mul_m    = (in_val[2*OPW-1:0] + ((2*OPW)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
    assign round_up = {in_rem, 1'b0} >= {1'b0, in_den};
    assign div_m    = (NUM_W+1)'(in_num) + (NUM_W+1)'(round_up);
    assign mag_w    = (in_ctl.op == OP_MUL) ? WIDE_W'(mul_m) : WIDE_W'(div_m);

    always_comb
    begin
        if (in_ctl.op == OP_MUL || in_ctl.op == OP_DIV)
            res_a_next = in_ctl.neg ? -mag_w : mag_w;
        else
            res_a_next = in_val;
    end

    always_comb
    begin
        priority if (ctl_a_reg.div_zero)
        begin
            data_next   = '0;
            status_next = ST_DIVZ;
        end
        else if (ctl_a_reg.clamp && res_a_reg > HI)
        begin
            data_next   = HI[OPW-1:0];
            status_next = ST_OVF;
        end
        else if (ctl_a_reg.clamp && res_a_reg < LO)
        begin
            data_next   = LO[OPW-1:0];
            status_next = ST_OVF;
        end
        else
        begin
            data_next   = res_a_reg[OPW-1:0];
            status_next = ST_OK;
        end
    end

    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
                valid_a_reg <= in_valid;
            if (ready_b)
                valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            ctl_a_reg <= in_ctl;
            res_a_reg <= res_a_next;
        end
        if (ready_b && valid_a_reg)
        begin
            data_reg   <= data_next;
            cmp_reg    <= ctl_a_reg.cmp;
            status_reg <= status_next;
        end
    end

    assign out_valid    = valid_b_reg;
    assign result_value = data_reg;
    assign compare_true = cmp_reg;
    assign status       = status_reg;
endmodule
`default_nettype wire

// File: hw/rtl/fixed_point_q24_8_alu.sv
// Signed Q24.8 fixed-point ALU: top level, chaining front, division cells and finish.
// Depends on fxq_pkg, fxq_front, fxq_div_cell, fxq_finish and the assertion header.
//
// One request per cycle is taken while s_tready is high, each carrying an
// operation (tuser) and two raw fixed-point operands (tdata); exactly one result
// comes back per request, in order. Every request, whatever its operation,
// travels the same pipeline so order is kept: a decode stage (magnitudes, the
// 32x32 product, add/sub/compare and the other simple results), then a row of
// 32+FRAC_BITS identical division cells that each produce one quotient bit, then
// a rounding stage and a saturating output register. The sustained rate is one
// request per cycle while m_tready stays high; the depth is set by the division
// cell row. Each stage holds its request only while the next is full, so bubbles
// close up and a request is still taken while a finished result waits on m_tready.
// Multiply and divide round to nearest with halves away from zero; results out of
// the signed DATA_WIDTH-bit range saturate with status overflow, and division by
// zero returns 0 with status divide-by-zero. Nothing needs clearing after reset.
`default_nettype none
`include "fixed_point_q24_8_alu_assert.svh"
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  wire  [3:0]  s_tuser,   // [3:0] operation
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [2:0]  m_tuser    // [0] compare_true, [2:1] status
);
    import fxq_pkg::*;

    localparam int NUM_W = OPW + FRAC_BITS;   // numerator bits, one cell each
    localparam logic signed [WIDE_W-1:0] HI_W = (WIDE_W'(1) <<< (DATA_WIDTH-1)) - WIDE_W'(1);
    localparam logic [OPW-1:0] HI32 = HI_W[OPW-1:0];
    localparam logic [OPW-1:0] LO32 = ~HI32;

    // stage s is the output of the front (s=0) or of cell s-1
    logic [NUM_W:0]           v_q;
    logic [NUM_W:0]           rdy;
    ctl_t                     ctl_q [NUM_W+1];
    logic signed [WIDE_W-1:0] val_q [NUM_W+1];
    logic [NUM_W-1:0]         num_q [NUM_W+1];
    logic [OPW-1:0]           rem_q [NUM_W+1];
    logic [OPW-1:0]           den_q [NUM_W+1];

    logic [OPW-1:0]           result_value;
    logic                     compare_true;
    logic [1:0]               status;

    fxq_front #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .operation (s_tuser),
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .out_valid (v_q[0]),
        .out_ready (rdy[0]),
        .out_ctl   (ctl_q[0]),
        .out_val   (val_q[0]),
        .out_num   (num_q[0]),
        .out_den   (den_q[0])
    );

    assign rem_q[0] = '0;

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_cell
        fxq_div_cell #(
            .NUM_W (NUM_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_q[i]),
            .in_ready  (rdy[i]),
            .in_ctl    (ctl_q[i]),
            .in_val    (val_q[i]),
            .in_num    (num_q[i]),
            .in_rem    (rem_q[i]),
            .in_den    (den_q[i]),
            .out_valid (v_q[i+1]),
            .out_ready (rdy[i+1]),
            .out_ctl   (ctl_q[i+1]),
            .out_val   (val_q[i+1]),
            .out_num   (num_q[i+1]),
            .out_rem   (rem_q[i+1]),
            .out_den   (den_q[i+1])
        );
    end

    fxq_finish #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH),
        .NUM_W      (NUM_W)
    ) u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (v_q[NUM_W]),
        .in_ready     (rdy[NUM_W]),
        .in_ctl       (ctl_q[NUM_W]),
        .in_val       (val_q[NUM_W]),
        .in_num       (num_q[NUM_W]),
        .in_rem       (rem_q[NUM_W]),
        .in_den       (den_q[NUM_W]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .result_value (result_value),
        .compare_true (compare_true),
        .status       (status)
    );

    assign m_tdata = result_value;
    assign m_tuser = {status, compare_true};

    // input held off only when every stage is full and the output is stalled
    `FXQ_ASSERT_IMP(a_stall_full, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    // a taken request lands in the decode stage
    `FXQ_ASSERT_NEXT(a_accept_lands, clk, rst_n, s_tvalid && s_tready, v_q[0])
    // divide-by-zero gives zero, no compare flag
    `FXQ_ASSERT_IMP(a_divz_zero, clk, rst_n, m_tvalid && status == ST_DIVZ,
                    result_value == '0 && !compare_true)
    // saturated results sit on a range bound
    `FXQ_ASSERT_IMP(a_ovf_bound, clk, rst_n, m_tvalid && status == ST_OVF,
                    result_value == HI32 || result_value == LO32)
    // a true compare returns zero data and ok status
    `FXQ_ASSERT_IMP(a_cmp_clean, clk, rst_n, m_tvalid && compare_true,
                    result_value == '0 && status == ST_OK)
endmodule
`default_nettype wire

// File: dv/tb_fixed_point_q24_8_alu.sv
// Self-checking bench for the Q24.8 fixed-point ALU: directed table then random requests.
// Depends on fxq_pkg and the fixed_point_q24_8_alu top level.
`default_nettype none
module tb_fixed_point_q24_8_alu;
    import fxq_pkg::*;

    localparam int FRAC = 8;
    localparam int LATENCY = 32 + FRAC + 3;

    typedef struct {
        logic [31:0] value;
        logic        flag;
        logic [1:0]  stat;
    } alu_res_t;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic        typed;     // expected result given in the row
        alu_res_t    res;
    } vec_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] operand_a, [63:32] operand_b
    logic [3:0]  s_tuser;   // [3:0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] result_value
    logic [2:0]  m_tuser;   // [0] compare_true, [2:1] status

    alu_res_t pending_results[$];
    int       fail_count;
    int       result_count;
    int       send_idle_pct;
    int       recv_stall_pct;
    vec_t     directed[$];

    fixed_point_q24_8_alu u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturate a wide signed value to 32 bits, flagging overflow.
    function automatic void saturate(input logic signed [95:0] r, inout alu_res_t res);
        if (r > 96'sh7FFFFFFF)
        begin
            res.value = 32'h7FFFFFFF;
            res.stat  = ST_OVF;
        end
        else if (r < -96'sh80000000)
        begin
            res.value = 32'h80000000;
            res.stat  = ST_OVF;
        end
        else
            res.value = r[31:0];
    endfunction

    // Exact fixed-point behaviour of one ALU request.
    function automatic alu_res_t alu_compute(input logic [3:0] op, input logic [31:0] a_raw,
                                             input logic [31:0] b_raw);
        alu_res_t res;
        logic signed [95:0] a;
        logic signed [95:0] b;
        logic [95:0] ma;
        logic [95:0] mb;
        logic [95:0] m;
        logic neg;
        a = {{64{a_raw[31]}}, a_raw};
        b = {{64{b_raw[31]}}, b_raw};
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        neg = a_raw[31] != b_raw[31];
        res.value = '0;
        res.flag  = 1'b0;
        res.stat  = ST_OK;
        case (op)
            OP_ADD:  saturate(a + b, res);
            OP_SUB:  saturate(a - b, res);
            OP_MUL:
            begin
                m = (ma * mb + (96'd1 << (FRAC - 1))) >> FRAC;
                saturate(neg ? -$signed(m) : $signed(m), res);
            end
            OP_DIV:
            begin
                if (b_raw == 32'd0)
                    res.stat = ST_DIVZ;
                else
                begin
                    m = (2 * (ma << FRAC) + mb) / (2 * mb);
                    saturate(neg ? -$signed(m) : $signed(m), res);
                end
            end
            OP_LT:   res.flag = a < b;
            OP_GT:   res.flag = a > b;
            OP_LE:   res.flag = a <= b;
            OP_GE:   res.flag = a >= b;
            OP_EQ:   res.flag = a == b;
            OP_NE:   res.flag = a != b;
            OP_MIN:  res.value = (a < b) ? a_raw : b_raw;
            OP_MAX:  res.value = (a > b) ? a_raw : b_raw;
            OP_INC:  saturate(a + 1, res);
            OP_DEC:  saturate(a - 1, res);
            OP_FINT: saturate(a * 256, res);
            default: res.value = $signed(a_raw) >>> FRAC;
        endcase
        return res;
    endfunction

    function automatic vec_t row(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                                 input int typed = 0, input logic [31:0] v = '0,
                                 input int f = 0, input logic [1:0] s = ST_OK);
        vec_t r;
        r.op = op;
        r.a = a;
        r.b = b;
        r.typed = (typed != 0);
        r.res.value = v;
        r.res.flag = (f != 0);
        r.res.stat = s;
        return r;
    endfunction

    // Present one request and hold it until accepted; gaps follow send_idle_pct.
    task automatic send_request(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                                input logic typed, input alu_res_t res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b, a};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(typed ? res : alu_compute(op, a, b));
    endtask

    task automatic release_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0:       return $urandom_range(2047) - 1024;        // near zero
            1:       return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom)};
            2:       return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(3)
                                              : 32'h80000000 + $urandom_range(3);
            3:       return {16'($urandom_range(1) ? 16'hFFFF : 16'h0000), 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls, checks every accepted result in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result value=%h flags=%b", $time, m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    alu_res_t e;
                    e = pending_results.pop_front();
                    result_count++;
                    if (m_tdata !== e.value)
                    begin
                        $display("%0t: result_value expected %h actual %h", $time, e.value, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0] !== e.flag)
                    begin
                        $display("%0t: compare_true expected %b actual %b", $time, e.flag,
                                 m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[2:1] !== e.stat)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, e.stat,
                                 m_tuser[2:1]);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        alu_res_t none;
        int phase;
        none = '{default: '0};
        fail_count = 0;
        result_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_ADD;
        m_tready = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation, saturation, divide by zero, ties.
        directed.push_back(row(OP_ADD, 32'h7FFFFFFF, 32'h1, 1, 32'h7FFFFFFF, 0, ST_OVF));
        directed.push_back(row(OP_ADD, 32'h80000000, 32'h80000000, 1, 32'h80000000, 0, ST_OVF));
        directed.push_back(row(OP_SUB, 32'h80000000, 32'h1, 1, 32'h80000000, 0, ST_OVF));
        directed.push_back(row(OP_SUB, 32'h0, 32'h80000000, 1, 32'h7FFFFFFF, 0, ST_OVF));
        directed.push_back(row(OP_MUL, 32'h00000180, 32'hFFFFFE80));
        directed.push_back(row(OP_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 0, ST_OVF));
        directed.push_back(row(OP_MUL, 32'h80000000, 32'h80000000, 1, 32'h7FFFFFFF, 0, ST_OVF));
        directed.push_back(row(OP_MUL, 32'h00000001, 32'hFFFFFF80));   // half rounds away
        directed.push_back(row(OP_DIV, 32'h12345678, 32'h0, 1, 32'h0, 0, ST_DIVZ));
        directed.push_back(row(OP_DIV, 32'h80000000, 32'h0, 1, 32'h0, 0, ST_DIVZ));
        directed.push_back(row(OP_DIV, 32'h00000100, 32'h00000300));
        directed.push_back(row(OP_DIV, 32'h80000000, 32'h00000001, 1, 32'h80000000, 0, ST_OVF));
        directed.push_back(row(OP_DIV, 32'h80000000, 32'h80000000, 1, 32'h00000100, 0, ST_OK));
        directed.push_back(row(OP_LT, 32'h80000000, 32'h7FFFFFFF, 1, 32'h0, 1, ST_OK));
        directed.push_back(row(OP_GT, 32'h80000000, 32'h7FFFFFFF, 1, 32'h0, 0, ST_OK));
        directed.push_back(row(OP_LE, 32'h5, 32'h5, 1, 32'h0, 1, ST_OK));
        directed.push_back(row(OP_GE, 32'hFFFFFFFF, 32'h0, 1, 32'h0, 0, ST_OK));
        directed.push_back(row(OP_EQ, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'h0, 1, ST_OK));
        directed.push_back(row(OP_NE, 32'h0, 32'h0, 1, 32'h0, 0, ST_OK));
        directed.push_back(row(OP_MIN, 32'h80000000, 32'h7FFFFFFF, 1, 32'h80000000, 0, ST_OK));
        directed.push_back(row(OP_MAX, 32'h80000000, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 0, ST_OK));
        directed.push_back(row(OP_INC, 32'h7FFFFFFF, 32'hFFFFFFFF, 1, 32'h7FFFFFFF, 0, ST_OVF));
        directed.push_back(row(OP_DEC, 32'h80000000, 32'h0, 1, 32'h80000000, 0, ST_OVF));
        directed.push_back(row(OP_FINT, 32'h00800000, 32'h0, 1, 32'h7FFFFFFF, 0, ST_OVF));
        directed.push_back(row(OP_TINT, 32'hFFFFFFFF, 32'h0, 1, 32'hFFFFFFFF, 0, ST_OK));
        foreach (directed[i])
            send_request(directed[i].op, directed[i].a, directed[i].b, directed[i].typed,
                         directed[i].res);

        // Hold off until the pipe has drained completely.
        release_sender();
        while (pending_results.size() != 0)
            @(posedge clk);

        // Random: four idling phases, one with no gaps or stalls at all.
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 52 : (phase == 3) ? 27 : 0;
            recv_stall_pct = (phase == 2) ? 52 : (phase == 3) ? 27 : 0;
            repeat (220)
            begin
                logic [3:0] op;
                logic [31:0] a;
                logic [31:0] b;
                op = 4'($urandom_range(15));
                a = rand_operand();
                b = ($urandom_range(9) == 0) ? a : rand_operand();
                if (op == OP_DIV && $urandom_range(11) == 0)
                    b = '0;
                send_request(op, a, b, 1'b0, none);
            end
        end
        release_sender();

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Checked %0d results over all sixteen operations,", result_count);
        $display("with saturation, divide by zero and four flow-control patterns.");
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
